FILE: hdl/skct_pkg.sv
package skct_pkg;

    localparam int MODE_W        = 2;
    localparam int KEY_FIELD_W   = 64;
    localparam int INDEX_W       = 6;
    localparam int COUNT_FIELD_W = 32;
    localparam int LENGTH_W      = 7;

    // Input tdata: key, index, zero padding to whole bytes.
    localparam int IN_TDATA_W  = 72;
    // Output tdata: hit, count, entry_key, length, full_res, zero padding.
    localparam int OUT_TDATA_W = 112;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    // Compare-phase control broadcast to every cell.
    typedef struct packed {
        logic                 en;
        logic                 is_read;
        logic [INDEX_W-1:0]   index;
    } t_cmp;

    // Update-phase control broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic inc;
    } t_upd;

endpackage

FILE: hdl/skct_cell.sv
module skct_cell #(
    parameter int KEY_W      = 64,
    parameter int COUNT_BITS = 32,
    parameter int IDX        = 0
) (
    input  logic                   i_clk,
    input  skct_pkg::t_cmp         i_cmp,
    input  skct_pkg::t_upd         i_upd,
    input  logic                   i_valid,
    input  logic [KEY_W-1:0]       i_key,
    input  logic [KEY_W-1:0]       i_prev_key,
    input  logic [COUNT_BITS-1:0]  i_prev_count,
    input  logic                   i_prev_gt,
    output logic [KEY_W-1:0]       o_key,
    output logic [COUNT_BITS-1:0]  o_count,
    output logic                   o_gt,
    output logic                   o_eq
);
    import skct_pkg::*;

    logic [KEY_W-1:0]      r_key;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_gt;
    logic                  r_eq;
    logic                  w_idx_match;

    assign w_idx_match = (32'(IDX) == 32'(i_cmp.index));

    always_ff @(posedge i_clk) begin
        if (i_cmp.en) begin
            r_gt <= i_valid && !i_cmp.is_read && (r_key > i_key);
            r_eq <= i_valid && (i_cmp.is_read ? w_idx_match : (r_key == i_key));
        end
        if (i_upd.inc && r_eq && (r_count != {COUNT_BITS{1'b1}})) begin
            r_count <= r_count + COUNT_BITS'(1);
        end
        // Cells at or after the insert point take the new key or their neighbor's entry.
        if (i_upd.ins && !r_gt) begin
            if (i_prev_gt) begin
                r_key   <= i_key;
                r_count <= COUNT_BITS'(1);
            end else begin
                r_key   <= i_prev_key;
                r_count <= i_prev_count;
            end
        end
    end

    assign o_key   = r_key;
    assign o_count = r_count;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;

endmodule

FILE: hdl/sorted_key_count_table.sv
// Each item is compared against all cells in parallel when it is accepted (the compare
// registers load at acceptance); the update state then shifts or increments the cells
// and registers the result. A new item is not accepted until that update is done.
// The update waits while a previous result is still held on the output.
// Reset clears the entry count and the control state; stored entries are not cleared.
module sorted_key_count_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BYTES   = 8,
    parameter int COUNT_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: key[63:0], index[69:64], zero padding.
    input  logic [skct_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: mode[1:0].
    input  logic [skct_pkg::MODE_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: hit, count[32:1], entry_key[96:33], length[103:97],
    // full_res[104], zero padding.
    output logic [skct_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import skct_pkg::*;

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int TW    = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    t_state                  r_state;
    logic [TW-1:0]           r_total;
    logic [KEY_W-1:0]        r_key;
    logic [MODE_W-1:0]       r_mode;
    logic                    r_m_valid;
    logic [OUT_TDATA_W-1:0]  r_m_data;

    t_state                  n_state;
    logic [TW-1:0]           n_total;
    logic                    n_m_valid;
    logic [OUT_TDATA_W-1:0]  n_m_data;

    logic                    w_accept;
    logic                    w_go;
    logic [KEY_W-1:0]        w_bus_key;
    t_cmp                    w_cmp;
    t_upd                    w_upd;

    logic [KEY_W-1:0]        w_key   [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]   w_count [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  w_gt;
    logic [TABLE_DEPTH-1:0]  w_eq;
    logic [TABLE_DEPTH-1:0]  w_valid;

    logic                    w_any_eq;
    logic [KEY_W-1:0]        w_sel_key;
    logic [COUNT_BITS-1:0]   w_sel_count;
    logic [COUNT_BITS-1:0]   w_inc_count;
    logic                    w_full;

    logic                    n_hit;
    logic [COUNT_BITS-1:0]   n_count;
    logic [KEY_W-1:0]        n_entry_key;
    logic                    n_full_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_go          = (r_state == S_UPD) && (!r_m_valid || m_axis_tready);

    // The key bus carries the incoming key during compare and the held key during update.
    assign w_bus_key = (r_state == S_IDLE) ? s_axis_tdata[KEY_W-1:0] : r_key;

    assign w_cmp.en      = w_accept;
    assign w_cmp.is_read = (s_axis_tuser == MODE_READ);
    assign w_cmp.index   = s_axis_tdata[KEY_FIELD_W +: INDEX_W];

    assign w_full    = (r_total >= TW'(TABLE_DEPTH));
    assign w_upd.inc = w_go && (r_mode == MODE_ADD);
    assign w_upd.ins = w_go && (r_mode == MODE_ADD) && !w_any_eq && !w_full;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_valid[g] = (r_total > TW'(g));
        if (g == 0) begin : g_head
            skct_cell #(
                .KEY_W      (KEY_W),
                .COUNT_BITS (COUNT_BITS),
                .IDX        (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmp        (w_cmp),
                .i_upd        (w_upd),
                .i_valid      (w_valid[g]),
                .i_key        (w_bus_key),
                .i_prev_key   (w_bus_key),
                .i_prev_count ({COUNT_BITS{1'b0}}),
                .i_prev_gt    (1'b1),
                .o_key        (w_key[g]),
                .o_count      (w_count[g]),
                .o_gt         (w_gt[g]),
                .o_eq         (w_eq[g])
            );
        end else begin : g_body
            skct_cell #(
                .KEY_W      (KEY_W),
                .COUNT_BITS (COUNT_BITS),
                .IDX        (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmp        (w_cmp),
                .i_upd        (w_upd),
                .i_valid      (w_valid[g]),
                .i_key        (w_bus_key),
                .i_prev_key   (w_key[g-1]),
                .i_prev_count (w_count[g-1]),
                .i_prev_gt    (w_gt[g-1]),
                .o_key        (w_key[g]),
                .o_count      (w_count[g]),
                .o_gt         (w_gt[g]),
                .o_eq         (w_eq[g])
            );
        end
    end

    // At most one cell matches, so an AND-OR reduction selects its entry.
    always_comb begin
        w_sel_key   = '0;
        w_sel_count = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_sel_key   = w_sel_key   | (w_key[i]   & {KEY_W{w_eq[i]}});
            w_sel_count = w_sel_count | (w_count[i] & {COUNT_BITS{w_eq[i]}});
        end
    end

    assign w_any_eq    = |w_eq;
    assign w_inc_count = (w_sel_count == {COUNT_BITS{1'b1}}) ? w_sel_count
                                                             : w_sel_count + COUNT_BITS'(1);

    always_comb begin
        n_total     = r_total;
        n_hit       = 1'b0;
        n_count     = '0;
        n_entry_key = '0;
        n_full_res  = 1'b0;
        case (r_mode)
            MODE_ADD: begin
                if (w_any_eq) begin
                    n_hit   = 1'b1;
                    n_count = w_inc_count;
                end else if (w_full) begin
                    n_full_res = 1'b1;
                end else begin
                    n_count = COUNT_BITS'(1);
                    n_total = r_total + TW'(1);
                end
            end
            MODE_READ: begin
                n_hit       = w_any_eq;
                n_count     = w_sel_count;
                n_entry_key = w_sel_key;
            end
            MODE_CLEAR: begin
                n_total = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_go) begin
                    n_state   = S_IDLE;
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, n_full_res, LENGTH_W'(n_total),
                                 KEY_FIELD_W'(n_entry_key), COUNT_FIELD_W'(n_count), n_hit};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (w_go) begin
                r_total <= n_total;
            end
        end
        r_m_data <= n_m_data;
        if (w_accept) begin
            r_key  <= s_axis_tdata[KEY_W-1:0];
            r_mode <= s_axis_tuser;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

FILE: tb/sorted_key_count_table_checker.sv
`timescale 1ns / 1ps

module sorted_key_count_table_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // Fields from bit 0: key[63:0], index[69:64], zero padding.
    input  logic [skct_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Fields from bit 0: mode[1:0].
    input  logic [skct_pkg::MODE_W-1:0]      i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // Fields from bit 0: hit, count[32:1], entry_key[96:33], length[103:97],
    // full_res[104], zero padding.
    input  logic [skct_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                               o_mismatches,
    output int                               o_pending
);
    import skct_pkg::*;

    localparam logic [COUNT_FIELD_W-1:0] COUNT_MAX = '1;

    // Declared from the top bit down so that hit lands in bit 0.
    typedef struct packed {
        logic                     full_res;
        logic [LENGTH_W-1:0]      length;
        logic [KEY_FIELD_W-1:0]   entry_key;
        logic [COUNT_FIELD_W-1:0] count;
        logic                     hit;
    } t_table_result;

    localparam int RESULT_W = $bits(t_table_result);

    logic [KEY_FIELD_W-1:0]   tbl_keys [TABLE_DEPTH];
    logic [COUNT_FIELD_W-1:0] tbl_counts [TABLE_DEPTH];
    int                       tbl_len = 0;
    t_table_result            expected_q [$];
    int                       mismatch_total = 0;

    // Applies one item to the predicted table and returns the result it should give.
    function automatic t_table_result tally_item(logic [MODE_W-1:0] mode,
                                                 logic [KEY_FIELD_W-1:0] key,
                                                 logic [INDEX_W-1:0] idx);
        t_table_result r;
        int pos;
        r = '0;
        case (mode)
            MODE_ADD: begin
                // Entries run from the largest key down; stop at the first one not larger.
                pos = 0;
                while (pos < tbl_len && tbl_keys[pos] > key) pos++;
                if (pos < tbl_len && tbl_keys[pos] == key) begin
                    if (tbl_counts[pos] != COUNT_MAX) tbl_counts[pos]++;
                    r.hit   = 1'b1;
                    r.count = tbl_counts[pos];
                end else if (tbl_len >= TABLE_DEPTH) begin
                    r.full_res = 1'b1;
                end else begin
                    for (int i = tbl_len; i > pos; i--) begin
                        tbl_keys[i]   = tbl_keys[i-1];
                        tbl_counts[i] = tbl_counts[i-1];
                    end
                    tbl_keys[pos]   = key;
                    tbl_counts[pos] = 1;
                    tbl_len++;
                    r.count = 1;
                end
            end
            MODE_READ: begin
                if (int'(idx) < tbl_len) begin
                    r.hit       = 1'b1;
                    r.count     = tbl_counts[idx];
                    r.entry_key = tbl_keys[idx];
                end
            end
            MODE_CLEAR: tbl_len = 0;
            default: ;
        endcase
        r.length = LENGTH_W'(tbl_len);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin : watch
        t_table_result got;
        t_table_result want;
        if (!i_rst_n) begin
            tbl_len = 0;
            expected_q.delete();
        end else begin
            // Results first: an item accepted at this edge cannot be answered yet.
            if (i_m_tvalid && i_m_tready) begin
                got = t_table_result'(i_m_tdata[RESULT_W-1:0]);
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with no item waiting", got));
                end else begin
                    want = expected_q.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("hit is %0b, expected %0b",
                                                  got.hit, want.hit));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("count is 0x%0h, expected 0x%0h",
                                                  got.count, want.count));
                    if (got.entry_key !== want.entry_key)
                        report_mismatch($sformatf("entry_key is 0x%0h, expected 0x%0h",
                                                  got.entry_key, want.entry_key));
                    if (got.length !== want.length)
                        report_mismatch($sformatf("length is %0d, expected %0d",
                                                  got.length, want.length));
                    if (got.full_res !== want.full_res)
                        report_mismatch($sformatf("full_res is %0b, expected %0b",
                                                  got.full_res, want.full_res));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_q.push_back(tally_item(i_s_tuser, i_s_tdata[KEY_FIELD_W-1:0],
                                                i_s_tdata[KEY_FIELD_W +: INDEX_W]));
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatch_total;
    end

endmodule

FILE: tb/sorted_key_count_table_test.sv
`timescale 1ns / 1ps

module sorted_key_count_table_test;
    import skct_pkg::*;

    // The mode code the block leaves unused; it must change nothing.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int TABLE_DEPTH  = 64;
    localparam int ITEM_TARGET  = 950;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]      s_axis_tuser = MODE_CLEAR;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;
    int mismatches;
    int pending;

    // Keys added since the last clear, used to aim adds at existing entries.
    logic [KEY_FIELD_W-1:0] added_keys [$];

    sorted_key_count_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (8),
        .COUNT_BITS  (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sorted_key_count_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) table_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic [MODE_W-1:0] mode, logic [KEY_FIELD_W-1:0] key,
                             logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - KEY_FIELD_W - INDEX_W){1'b0}}, idx, key};
        s_axis_tuser  <= mode;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if (mode != MODE_SPARE) items_sent++;
        if (mode == MODE_CLEAR) added_keys.delete();
        else if (mode == MODE_ADD) added_keys.push_back(key);
    endtask

    function automatic logic [KEY_FIELD_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [INDEX_W-1:0] random_index();
        return INDEX_W'($urandom);
    endfunction

    // Mix of repeats, tightly packed neighbors, boundary values and wide random keys.
    function automatic logic [KEY_FIELD_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35 && added_keys.size() > 0)
            return added_keys[$urandom_range(added_keys.size() - 1)];
        if (roll < 45) return KEY_FIELD_W'($urandom_range(15));
        if (roll < 50) return '1 - KEY_FIELD_W'($urandom_range(15));
        if (roll < 58) begin
            case ($urandom_range(3))
                0: return 64'h8000_0000_0000_0000;
                1: return 64'h7FFF_FFFF_FFFF_FFFF;
                2: return '1;
                default: return 64'd1 << $urandom_range(63);
            endcase
        end
        return random_key();
    endfunction

    // Fills the table from empty with fresh keys, then works against a full table.
    task automatic fill_episode();
        send_item(MODE_CLEAR, random_key(), random_index());
        for (int i = 0; i < TABLE_DEPTH + 4; i++)
            send_item(MODE_ADD, random_key(), random_index());
        repeat (16) begin
            case ($urandom_range(2))
                0: send_item(MODE_ADD, pick_key(), random_index());
                1: send_item(MODE_ADD, random_key(), random_index());
                default: send_item(MODE_READ, random_key(), random_index());
            endcase
        end
    endtask

    task automatic mixed_episode();
        int ops;
        int unsigned roll;
        ops = $urandom_range(40, 8);
        // Most episodes start clean; the rest build on whatever the table holds.
        if ($urandom_range(3) != 0) send_item(MODE_CLEAR, random_key(), random_index());
        repeat (ops) begin
            roll = $urandom_range(99);
            if (roll < 55)
                send_item(MODE_ADD, pick_key(), random_index());
            else if (roll < 88)
                send_item(MODE_READ, random_key(),
                          $urandom_range(1) ? INDEX_W'($urandom_range(7)) : random_index());
            else if (roll < 94)
                send_item(MODE_SPARE, random_key(), random_index());
            else
                send_item(MODE_CLEAR, random_key(), random_index());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Read past the end of an empty table.
        send_item(MODE_READ, '1, '1);
        send_item(MODE_ADD, '1, '0);
        send_item(MODE_ADD, '0, '1);
        send_item(MODE_ADD, 64'h8000_0000_0000_0000, '0);
        send_item(MODE_ADD, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_item(MODE_ADD, '1, '0);
        send_item(MODE_ADD, '0, '0);
        send_item(MODE_READ, '0, 6'd0);
        send_item(MODE_READ, '0, 6'd1);
        send_item(MODE_READ, '0, 6'd2);
        send_item(MODE_READ, '0, 6'd3);
        send_item(MODE_READ, '0, 6'd4);
        send_item(MODE_READ, '0, '1);
        send_item(MODE_SPARE, 64'h0123_4567_89AB_CDEF, 6'd0);
        send_item(MODE_CLEAR, 64'hFEDC_BA98_7654_3210, '1);
        send_item(MODE_READ, '0, 6'd0);
        // First add after a clear starts a new list.
        send_item(MODE_ADD, 64'h0123_4567_89AB_CDEF, '0);
        send_item(MODE_READ, '0, 6'd0);
        send_item(MODE_ADD, 64'h0123_4567_89AB_CDEF, '0);
        send_item(MODE_ADD, 64'h0123_4567_89AB_CDEE, '0);
        send_item(MODE_READ, '0, 6'd1);

        // Count saturation needs 2^32 adds of one key and is out of reach here.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            fill_episode();
            while (items_sent < (ITEM_TARGET * (phase + 1)) / 4) mixed_episode();
        end

        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
